// ===== rtl/core/bpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page-frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  // Page index / count width (covers 0..131071)
  localparam int unsigned IdxW       = 17;
  // Occupancy map word width and its bit-offset width
  localparam int unsigned WordW      = 32;
  localparam int unsigned OffW       = 5;
  // Word counter width over the full index range
  localparam int unsigned WcntW      = IdxW - OffW;
  localparam int unsigned DefMaxPages = 65536;
  localparam logic [IdxW-1:0] CntMax   = 17'h1FFFF;
  localparam logic [IdxW-1:0] TotalRst = 17'h10000;

  typedef enum logic [2:0] {
    OP_REQUEST   = 3'd0,
    OP_FREE      = 3'd1,
    OP_LOCK      = 3'd2,
    OP_RESERVE   = 3'd3,
    OP_UNRESERVE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_FIN
  } bk_state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] page_index;
    logic [16:0] page_count;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] result_page;
    logic [16:0] changed_pages;
    logic [16:0] free_pages;
    logic [16:0] used_pages;
    logic [16:0] reserved_pages;
  } out_item_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic            known;     // operation code is defined
    op_e             op;
    logic [IdxW-1:0] first;     // first page of the run
    logic [IdxW-1:0] stop;      // exclusive end, clipped to the total
  } job_t;

endpackage

// ===== rtl/core/bitmap_page_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// Top level: configuration register, front decoder/queue and back executor.
// ----------------------------------------------------------------------------
// After reset the map is cleared one 32-page word per cycle, covering
// ceil(MAX_PAGES/32) words (2048 at the default) before the first transaction
// is executed. A job takes a memory read, then an update and write back, for
// each map word it touches, besides job pickup and result handoff; a request
// ends at the first word that holds a free page, and long runs and long scans
// touch one more word per 32 pages. Jobs that touch no word (zero count on
// any operation but a request, unknown code, run or hint at or past the total)
// go straight from pickup to result handoff. A two-entry job queue keeps
// accepting while the back end works until both entries are full, and the
// result register holds one finished result.
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int unsigned MAX_PAGES = DefMaxPages
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IdxW-1:0] cfg_data_i
);

  localparam int unsigned MaxCap = (MAX_PAGES > 131071) ? 131071 : MAX_PAGES;

  logic [IdxW-1:0] total_q, total_d, total_eff;
  logic            job_valid, job_pop;
  job_t            job;

  // Total pages register
  assign cfg_ready_o = 1'b1;
  assign total_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : total_q;
  assign total_eff   = (total_q > IdxW'(MaxCap)) ? IdxW'(MaxCap) : total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalRst;
    end else begin
      total_q <= total_d;
    end
  end

  bpfa_front u_front (
    .clk_i,
    .rst_ni,
    .total_i     (total_eff),
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  bpfa_back #(.MAX_PAGES(MAX_PAGES)) u_back (
    .clk_i,
    .rst_ni,
    .total_i     (total_eff),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule

// ===== rtl/core/bpfa_front.sv =====
// ----------------------------------------------------------------------------
// bpfa_front
// Accepts transactions, decodes the operation, clips the run to the managed
// total and queues the job for the back end (two entries).
// ----------------------------------------------------------------------------
module bpfa_front import bpfa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] total_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            job_valid_o,
  output job_t            job_o,
  input  logic            job_pop_i
);

  job_t          q_mem_q [2];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  job_t          job_new;
  logic [IdxW:0] run_sum;
  logic          push;

  // Decode and clip
  always_comb begin
    job_new.known = 1'b1;
    job_new.op    = OP_REQUEST;
    unique case (in_data_i.operation)
      OP_REQUEST:   job_new.op = OP_REQUEST;
      OP_FREE:      job_new.op = OP_FREE;
      OP_LOCK:      job_new.op = OP_LOCK;
      OP_RESERVE:   job_new.op = OP_RESERVE;
      OP_UNRESERVE: job_new.op = OP_UNRESERVE;
      default:      job_new.known = 1'b0;
    endcase
    job_new.first = {1'b0, in_data_i.page_index};
    run_sum       = {1'b0, job_new.first} + {1'b0, in_data_i.page_count};
    job_new.stop  = (run_sum > {1'b0, total_i}) ? total_i : run_sum[IdxW-1:0];
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem_q[rd_ptr_q];

  // Queue pointers
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = job_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, job_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

// ===== rtl/core/bpfa_back.sv =====
// ----------------------------------------------------------------------------
// bpfa_back
// Executes queued jobs word by word over the occupancy map memory, keeps the
// hint and the page counts, and holds the result register.
// ----------------------------------------------------------------------------
module bpfa_back import bpfa_pkg::*; #(
  parameter int unsigned MAX_PAGES = DefMaxPages
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] total_i,
  input  logic            job_valid_i,
  input  job_t            job_i,
  output logic            job_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o
);

  localparam int unsigned Depth = (MAX_PAGES + WordW - 1) / WordW;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;

  bk_state_e       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  job_t            job_q, job_d;
  logic [WcntW-1:0] wcnt_q, wcnt_d;
  logic [IdxW-1:0] hint_q, hint_d, used_q, used_d, res_q, res_d;
  logic [IdxW-1:0] chg_q, chg_d, page_q, page_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic             we;
  logic [AddrW-1:0] waddr;
  logic [WordW-1:0] wdata;

  logic [IdxW-1:0]  base, last_idx, low_idx, stop_m1;
  logic [OffW:0]    lo, hi;
  logic [WordW-1:0] mask, cand, flip;
  logic [OffW-1:0]  low_bit;
  logic [OffW:0]    pop;
  logic             last_word, clearing;
  logic [IdxW:0]    sum_c, used_res;

  // Per-word evaluation
  always_comb begin
    base     = {wcnt_q, {OffW{1'b0}}};
    stop_m1  = job_q.stop - 17'd1;
    lo       = (wcnt_q == job_q.first[IdxW-1:OffW]) ? {1'b0, job_q.first[OffW-1:0]} : '0;
    hi       = (wcnt_q == job_q.stop[IdxW-1:OffW]) ? {1'b0, job_q.stop[OffW-1:0]}
                                                    : (OffW+1)'(WordW);
    for (int b = 0; b < WordW; b++) begin
      mask[b] = ((OffW+1)'(b) >= lo) && ((OffW+1)'(b) < hi);
    end
    clearing = (job_q.op == OP_FREE) || (job_q.op == OP_UNRESERVE);
    cand     = clearing ? (mask & rdata_q) : (mask & ~rdata_q);
    low_bit  = '0;
    for (int b = WordW - 1; b >= 0; b--) begin
      if (cand[b]) low_bit = OffW'(b);
    end
    flip      = (job_q.op == OP_REQUEST) ? (cand & (~cand + 1'b1)) : cand;
    pop       = (OffW+1)'($countones(flip));
    low_idx   = base + {{(IdxW-OffW){1'b0}}, low_bit};
    last_word = (wcnt_q == stop_m1[IdxW-1:OffW]);
    last_idx  = job_q.stop;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    job_d       = job_q;
    wcnt_d      = wcnt_q;
    hint_d      = hint_q;
    used_d      = used_q;
    res_d       = res_q;
    chg_d       = chg_q;
    page_d      = page_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    job_pop_o   = 1'b0;
    we          = 1'b0;
    waddr       = AddrW'(wcnt_q);
    wdata       = rdata_q ^ flip;
    sum_c       = '0;
    used_res    = {1'b0, used_q} + {1'b0, res_q};

    unique case (state_q)
      // Zero the map word by word after reset
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        chg_d  = '0;
        page_d = '0;
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          if (job_i.op == OP_REQUEST) begin
            job_d.first = hint_q;
            job_d.stop  = total_i;
          end
          wcnt_d  = job_d.first[IdxW-1:OffW];
          state_d = (!job_d.known || job_d.stop <= job_d.first) ? ST_FIN : ST_RD;
        end
      end
      ST_RD: state_d = ST_EX;
      ST_EX: begin
        we     = (flip != '0);
        wcnt_d = wcnt_q + 1'b1;
        state_d = last_word ? ST_FIN : ST_RD;
        if (job_q.op == OP_REQUEST) begin
          if (cand != '0) begin
            page_d  = low_idx;
            hint_d  = low_idx;
            chg_d   = 17'd1;
            used_d  = (used_q >= CntMax) ? CntMax : used_q + 17'd1;
            state_d = ST_FIN;
          end else if (last_word) begin
            hint_d = last_idx;
          end
        end else begin
          chg_d = chg_q + {{(IdxW-OffW-1){1'b0}}, pop};
          unique case (job_q.op)
            OP_FREE: used_d = (used_q < {{(IdxW-OffW-1){1'b0}}, pop}) ? '0
                              : used_q - {{(IdxW-OffW-1){1'b0}}, pop};
            OP_UNRESERVE: res_d = (res_q < {{(IdxW-OffW-1){1'b0}}, pop}) ? '0
                                  : res_q - {{(IdxW-OffW-1){1'b0}}, pop};
            OP_LOCK: begin
              sum_c  = {1'b0, used_q} + {{(IdxW-OffW){1'b0}}, pop};
              used_d = (sum_c >= {1'b0, CntMax}) ? CntMax : sum_c[IdxW-1:0];
            end
            default: begin
              sum_c = {1'b0, res_q} + {{(IdxW-OffW){1'b0}}, pop};
              res_d = (sum_c >= {1'b0, CntMax}) ? CntMax : sum_c[IdxW-1:0];
            end
          endcase
          if (clearing && (flip != '0) && (low_idx < hint_q)) hint_d = low_idx;
        end
      end
      // Publish the result when the output register is free
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.granted        = (chg_q != '0);
          out_d.result_page    = page_q[15:0];
          out_d.changed_pages  = chg_q;
          out_d.free_pages     = (used_res >= {1'b0, total_i}) ? '0
                                 : total_i - used_res[IdxW-1:0];
          out_d.used_pages     = used_q;
          out_d.reserved_pages = res_q;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hint_q      <= '0;
      used_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      used_q      <= used_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    wcnt_q <= wcnt_d;
    chg_q  <= chg_d;
    page_q <= page_d;
    out_q  <= out_d;
  end

  // Occupancy map memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[AddrW'(wcnt_q)];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
